FILE: sv/bsm_pkg.sv
// Shared types and constants for the byte stack machine.
package bsm_pkg;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_EXEC  = 2'd1;
  localparam logic [1:0] FUNC_END   = 2'd2;

  // Instruction opcodes.
  localparam logic [7:0] OPC_PUSH = 8'h01;
  localparam logic [7:0] OPC_LOAD = 8'h02;
  localparam logic [7:0] OPC_XOR  = 8'h03;
  localparam logic [7:0] OPC_ADD  = 8'h04;
  localparam logic [7:0] OPC_ROTL = 8'h05;
  localparam logic [7:0] OPC_EQ   = 8'h06;
  localparam logic [7:0] OPC_HALT = 8'h07;

  // Rotate amounts are taken modulo eight.
  localparam logic [2:0] ROT_MASK = 3'd7;

  // Status codes of a result item.
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Width of the reported stack count.
  localparam int unsigned CountW = 7;

  // Operation class decided by the front end.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH,
    OP_LOAD,
    OP_XOR,
    OP_ADD,
    OP_ROTL,
    OP_EQ,
    OP_HALT,
    OP_FAIL
  } op_class_e;

  // Input item.
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] opcode;
    logic [7:0] immediate;
    logic [5:0] string_index;
    logic [7:0] string_byte;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        top_value;
    logic [CountW-1:0] stack_count;
  } out_item_t;

  // Classified item passed from front to back.
  typedef struct packed {
    op_class_e  op;
    logic [7:0] value;
  } op_item_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
  } q_status_t;

  // Queue head seen by the back end.
  typedef struct packed {
    logic     valid;
    op_item_t item;
  } q_head_t;

endpackage

FILE: sv/bsm_front.sv
// Front end: accepts items, holds the string store and classifies instructions.
module bsm_front import bsm_pkg::*; #(
  parameter int unsigned STRING_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output op_item_t  push_item_o
);

  localparam int unsigned SW = (STRING_DEPTH > 1) ? $clog2(STRING_DEPTH) : 1;

  logic [7:0]    str_mem [STRING_DEPTH];
  logic          in_fire;
  logic          str_wr;
  logic          idx_ok;
  logic          imm_ok;
  op_class_e     op_class;
  logic          s_valid_q, s_valid_d;
  op_class_e     s_op_q;
  logic [7:0]    s_imm_q;
  logic [7:0]    rd_q;

  // The stage register only holds when the queue cannot take its item.
  assign in_stall_o = s_valid_q && q_status_i.full;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign push_o     = s_valid_q && !q_status_i.full;
  assign s_valid_d  = in_fire || (s_valid_q && q_status_i.full);

  assign idx_ok = 9'(in_item_i.string_index) < 9'(STRING_DEPTH);
  assign imm_ok = 9'(in_item_i.immediate) < 9'(STRING_DEPTH);
  assign str_wr = in_fire && (in_item_i.func == FUNC_WRITE) && idx_ok;

  // Decode the function and opcode into an operation class.
  always_comb begin
    op_class = OP_NONE;
    case (in_item_i.func)
      FUNC_WRITE: op_class = OP_NONE;
      FUNC_EXEC: begin
        case (in_item_i.opcode)
          OPC_PUSH: op_class = OP_PUSH;
          OPC_LOAD: op_class = imm_ok ? OP_LOAD : OP_FAIL;
          OPC_XOR:  op_class = OP_XOR;
          OPC_ADD:  op_class = OP_ADD;
          OPC_ROTL: op_class = OP_ROTL;
          OPC_EQ:   op_class = OP_EQ;
          OPC_HALT: op_class = OP_HALT;
          default:  op_class = OP_FAIL;
        endcase
      end
      FUNC_END: op_class = OP_FAIL;
      default:  op_class = OP_NONE;
    endcase
  end

  // String store: one write port, one registered read port for LOAD.
  always_ff @(posedge clk_i) begin
    if (str_wr) begin
      str_mem[SW'(in_item_i.string_index)] <= in_item_i.string_byte;
    end
    if (in_fire) begin
      rd_q <= str_mem[SW'(in_item_i.immediate)];
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_op_q  <= op_class;
      s_imm_q <= in_item_i.immediate;
    end
  end

  // A LOAD carries the string byte; other operations carry the immediate.
  assign push_item_o.op    = s_op_q;
  assign push_item_o.value = (s_op_q == OP_LOAD) ? rd_q : s_imm_q;

endmodule

FILE: sv/bsm_queue.sv
// Two-entry queue between the front end and the back end.
module bsm_queue import bsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  op_item_t  push_item_i,
  output q_status_t status_o,
  input  logic      pop_i,
  output q_head_t   head_o
);

  op_item_t   entries_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign status_o.full = (count_q == 2'd2);
  assign head_o.valid  = (count_q != 2'd0);
  assign head_o.item   = entries_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: sv/bsm_back.sv
// Back end: runs instructions on the operand stack and registers the result item.
module bsm_back import bsm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_head_t   head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [7:0]    stk_mem [STACK_DEPTH];
  logic          fire;
  logic [DW-1:0] depth_q, depth_d;
  logic [DW:0]   depth_ext;
  logic          pass_q, pass_d;
  logic [7:0]    r0_q, r0_d;
  logic [7:0]    r1_q, r1_d;
  logic [7:0]    p2_q, p3_q;
  logic [1:0]    status;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd2_addr, rd3_addr;
  logic [15:0]   rot_dbl;
  logic [7:0]    alu_res;
  logic          out_valid_q;
  out_item_t     out_item_q;

  // An item runs when the result register is free or being emptied.
  assign fire  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  assign rot_dbl = {r0_q, r0_q} << (head_i.item.value[2:0] & ROT_MASK);
  assign alu_res = (head_i.item.op == OP_XOR) ? (r0_q ^ r1_q) : (r1_q + r0_q);

  // Execute one instruction; r0 and r1 hold the top two entries, p2 and p3
  // the next two, prefetched through the registered stack memory read ports.
  always_comb begin
    depth_d = depth_q;
    pass_d  = pass_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    status  = ST_RUN;
    wr_en   = 1'b0;
    if (fire) begin
      case (head_i.item.op)
        OP_PUSH, OP_LOAD: begin
          if (depth_q == DW'(STACK_DEPTH)) begin
            status = ST_FAIL;
          end else begin
            r0_d    = head_i.item.value;
            r1_d    = r0_q;
            depth_d = depth_q + DW'(1);
            wr_en   = 1'b1;
          end
        end
        OP_XOR, OP_ADD: begin
          if (depth_q < DW'(2)) begin
            status = ST_FAIL;
          end else begin
            r0_d    = alu_res;
            r1_d    = p2_q;
            depth_d = depth_q - DW'(1);
            wr_en   = 1'b1;
          end
        end
        OP_EQ: begin
          if (depth_q < DW'(2)) begin
            status = ST_FAIL;
          end else begin
            if (r0_q != r1_q) begin
              pass_d = 1'b0;
            end
            r0_d    = p2_q;
            r1_d    = p3_q;
            depth_d = depth_q - DW'(2);
          end
        end
        OP_ROTL: begin
          if (depth_q == '0) begin
            status = ST_FAIL;
          end else begin
            r0_d  = rot_dbl[15:8];
            wr_en = 1'b1;
          end
        end
        OP_HALT: status = pass_q ? ST_PASS : ST_FAIL;
        OP_FAIL: status = ST_FAIL;
        OP_NONE: status = ST_RUN;
        default: status = ST_RUN;
      endcase
    end
    // A finished run leaves an empty stack and a set pass flag.
    if (status != ST_RUN) begin
      depth_d = '0;
      pass_d  = 1'b1;
      wr_en   = 1'b0;
    end
  end

  // The written entry is always the new top; reads fetch the third and
  // fourth entries counting from the new top, which the write never touches.
  assign depth_ext = {1'b0, depth_d};
  assign wr_addr   = AW'(depth_ext - (DW + 1)'(1));
  assign rd2_addr  = AW'(depth_ext - (DW + 1)'(3));
  assign rd3_addr  = AW'(depth_ext - (DW + 1)'(4));

  // Operand stack memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stk_mem[wr_addr] <= r0_d;
    end
    p2_q <= stk_mem[rd2_addr];
    p3_q <= stk_mem[rd3_addr];
  end

  // Top-of-stack cache.
  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

  // Run state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      pass_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      pass_q      <= pass_d;
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q.status      <= status;
      out_item_q.top_value   <= (depth_d != '0) ? r0_d : 8'd0;
      out_item_q.stack_count <= CountW'(depth_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status != ST_RUN) |-> (out_item_q.stack_count == '0))
    else $error("finished run reports a non-empty stack");

  a_fail_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && head_i.item.op == OP_FAIL) |=>
      (out_valid_q && out_item_q.status == ST_FAIL))
    else $error("failing item did not report fail");

  a_new_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && status != ST_RUN) |=> (depth_q == '0 && pass_q))
    else $error("run end did not restore the initial state");
`endif

endmodule

FILE: sv/byte_stack_machine.sv
// Top level of the byte stack machine: front end, queue and back end.
// An accepted item passes the front stage, the queue and the result register.
// Throughput: one item per cycle unless stalled; the stack memory's two read ports
// prefetch the entries below the top, so dependent instructions run back to back.
// Reset: asynchronous, active low; empties the stack and sets the pass flag.
module byte_stack_machine import bsm_pkg::*; #(
  parameter int unsigned STACK_DEPTH  = 64,
  parameter int unsigned STRING_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  q_status_t q_status;
  q_head_t   q_head;
  logic      push;
  op_item_t  push_item;
  logic      pop;

  // Accept and classify.
  bsm_front #(
    .STRING_DEPTH(STRING_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .push_item_o(push_item)
  );

  // Decoupling queue.
  bsm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .status_o   (q_status),
    .pop_i      (pop),
    .head_o     (q_head)
  );

  // Execute.
  bsm_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (q_head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
